// ----- design/sli_pkg.sv -----
// shared types, constants and reply text tables for the serial led command interpreter
// no dependencies; used by every module of the block
package sli_pkg;

	// line buffer geometry: one slot is kept free, so a line holds LINE_BUFFER-1 characters
	localparam int LINE_BUFFER = 16;
	localparam int CNT_W       = $clog2(LINE_BUFFER);
	localparam int LINE_MAX    = LINE_BUFFER - 1;

	// only the first characters up to the longest command are ever compared
	localparam int TXT_KEEP = 7;
	localparam int TXT_IW   = $clog2(TXT_KEEP);

	// clock register
	localparam int                CLK_W     = 27;
	localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(16000000);
	localparam int                DIGITS    = 9;
	localparam int                BCD_W     = 4 * DIGITS;
	localparam int                CONV_CW   = $clog2(CLK_W);

	// reply text
	localparam int IDX_W   = 6;
	localparam int TAB_W   = 8 * (1 << IDX_W);

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;

	localparam logic [TAB_W-1:0] TXT_PING    = "OK PONG\r\n";
	localparam logic [TAB_W-1:0] TXT_VERSION = "OK FW 0.1\r\n";
	localparam logic [TAB_W-1:0] TXT_EXIT    =
		"OK DISCONNECTED\r\nCLOSE TERMINAL TO RECONNECT\r\n";
	localparam logic [TAB_W-1:0] TXT_HELP    =
		"OK Commands: R0/R1 G0/G1 B0/B1 X RGB:xyz STATE HELP\r\n";
	localparam logic [TAB_W-1:0] TXT_STATE   = "OK RGB=000\r\n";
	localparam logic [TAB_W-1:0] TXT_OK      = "OK\r\n";
	localparam logic [TAB_W-1:0] TXT_ERR     = "ERR\r\n";
	localparam logic [TAB_W-1:0] TXT_UPHEAD  = "OK ";

	localparam logic [IDX_W-1:0] LEN_PING    = IDX_W'(9);
	localparam logic [IDX_W-1:0] LEN_VERSION = IDX_W'(11);
	localparam logic [IDX_W-1:0] LEN_EXIT    = IDX_W'(46);
	localparam logic [IDX_W-1:0] LEN_HELP    = IDX_W'(53);
	localparam logic [IDX_W-1:0] LEN_STATE   = IDX_W'(12);
	localparam logic [IDX_W-1:0] LEN_OK      = IDX_W'(4);
	localparam logic [IDX_W-1:0] LEN_ERR     = IDX_W'(5);
	localparam logic [IDX_W-1:0] LEN_UPHEAD  = IDX_W'(3);
	localparam logic [IDX_W-1:0] LEN_UPTAIL  = IDX_W'(2);

	// led characters in the state reply
	localparam logic [IDX_W-1:0] POS_RED   = IDX_W'(7);
	localparam logic [IDX_W-1:0] POS_GREEN = IDX_W'(8);
	localparam logic [IDX_W-1:0] POS_BLUE  = IDX_W'(9);

	typedef enum logic [2:0] {
		CMD_UPTIME,
		CMD_PING,
		CMD_VERSION,
		CMD_EXIT,
		CMD_HELP,
		CMD_STATE,
		CMD_OK,
		CMD_ERR
	} cmd_t;

	// one classified line, with led and session state after the command
	typedef struct packed {
		cmd_t cmd;
		logic red;
		logic green;
		logic blue;
		logic open;
	} entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CONV,
		B_TRIM,
		B_SEND
	} bstate_t;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// byte i of an n-character string stored right-justified in a table word
	function automatic logic [7:0] txt_at(logic [TAB_W-1:0] s, logic [IDX_W-1:0] n,
		logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] pos;
		pos = n - i - IDX_W'(1);
		return s[{pos, 3'b000} +: 8];
	endfunction

	// length of a fixed reply
	function automatic logic [IDX_W-1:0] msg_len(cmd_t cmd);
		logic [IDX_W-1:0] n;
		unique case (cmd)
			CMD_PING:    n = LEN_PING;
			CMD_VERSION: n = LEN_VERSION;
			CMD_EXIT:    n = LEN_EXIT;
			CMD_HELP:    n = LEN_HELP;
			CMD_STATE:   n = LEN_STATE;
			CMD_OK:      n = LEN_OK;
			CMD_ERR:     n = LEN_ERR;
			default:     n = '0;
		endcase
		return n;
	endfunction

	// byte of a fixed reply
	function automatic logic [7:0] msg_byte(cmd_t cmd, logic [IDX_W-1:0] i);
		logic [7:0] b;
		unique case (cmd)
			CMD_PING:    b = txt_at(TXT_PING, LEN_PING, i);
			CMD_VERSION: b = txt_at(TXT_VERSION, LEN_VERSION, i);
			CMD_EXIT:    b = txt_at(TXT_EXIT, LEN_EXIT, i);
			CMD_HELP:    b = txt_at(TXT_HELP, LEN_HELP, i);
			CMD_STATE:   b = txt_at(TXT_STATE, LEN_STATE, i);
			CMD_OK:      b = txt_at(TXT_OK, LEN_OK, i);
			CMD_ERR:     b = txt_at(TXT_ERR, LEN_ERR, i);
			default:     b = CH_NUL;
		endcase
		return b;
	endfunction

endpackage

// ----- design/sli_front.sv -----
// front end: gathers received bytes into a line and classifies it on a terminator
// depends on sli_pkg; pushes one entry per non-empty finished line into the queue while the session is open
module sli_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rx_valid,
	output logic            rx_stall,
	input  logic [7:0]      rx_byte,
	input  logic            q_full,
	output logic            q_push,
	output sli_pkg::entry_t q_data
);
	import sli_pkg::*;

	logic [7:0]            text_q [TXT_KEEP];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      tlen_q;
	logic                  zero_q;
	logic                  red_q, green_q, blue_q, open_q;

	logic                  rx_fire, is_term;
	logic [8*TXT_KEEP-1:0] txt;
	logic [7:0]            u0, u1, u2, u3;
	logic                  bit_a, bit_b, bit_c;
	entry_t                ent;

	function automatic logic [7:0] upper(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic logic is_bit(logic [7:0] c);
		return c == CH_ZERO || c == CH_ONE;
	endfunction

	assign rx_stall = q_full;
	assign rx_fire  = rx_valid && !rx_stall;
	assign is_term  = rx_byte == CH_CR || rx_byte == CH_LF;

	// kept characters as one word, first character on top
	always_comb begin
		for (int i = 0; i < TXT_KEEP; i++) begin
			txt[8*(TXT_KEEP-1-i) +: 8] = text_q[i];
		end
	end

	assign u0 = upper(txt[55:48]);
	assign u1 = upper(txt[47:40]);
	assign u2 = upper(txt[39:32]);
	assign u3 = upper(txt[31:24]);
	assign bit_a = is_bit(txt[23:16]);
	assign bit_b = is_bit(txt[15:8]);
	assign bit_c = is_bit(txt[7:0]);

	// command match, in priority order, with the led and session update it implies
	always_comb begin
		ent.cmd   = CMD_ERR;
		ent.red   = red_q;
		ent.green = green_q;
		ent.blue  = blue_q;
		ent.open  = open_q;
		if (tlen_q == CNT_W'(6) && txt[55:8] == "UPTIME") begin
			ent.cmd = CMD_UPTIME;
		end else if (tlen_q == CNT_W'(4) && txt[55:24] == "PING") begin
			ent.cmd = CMD_PING;
		end else if (tlen_q == CNT_W'(7) && txt == "VERSION") begin
			ent.cmd = CMD_VERSION;
		end else if (tlen_q == CNT_W'(4) && u0 == "E" && u1 == "X" && u2 == "I" && u3 == "T") begin
			ent.cmd  = CMD_EXIT;
			ent.open = 1'b0;
		end else if (tlen_q == CNT_W'(4) && txt[55:24] == "HELP") begin
			ent.cmd = CMD_HELP;
		end else if (tlen_q == CNT_W'(5) && txt[55:16] == "STATE") begin
			ent.cmd = CMD_STATE;
		end else if (tlen_q == CNT_W'(1) && txt[55:48] == "X") begin
			ent.cmd   = CMD_OK;
			ent.red   = 1'b0;
			ent.green = 1'b0;
			ent.blue  = 1'b0;
		end else if (tlen_q == CNT_W'(7) && txt[55:24] == "RGB:" && bit_a && bit_b && bit_c) begin
			ent.cmd   = CMD_OK;
			ent.red   = txt[23:16] == CH_ONE;
			ent.green = txt[15:8] == CH_ONE;
			ent.blue  = txt[7:0] == CH_ONE;
		end else if (tlen_q == CNT_W'(2) && is_bit(txt[47:40]) &&
			(txt[55:48] == "R" || txt[55:48] == "G" || txt[55:48] == "B")) begin
			ent.cmd = CMD_OK;
			case (txt[55:48])
				"R":     ent.red   = txt[47:40] == CH_ONE;
				"G":     ent.green = txt[47:40] == CH_ONE;
				default: ent.blue  = txt[47:40] == CH_ONE;
			endcase
		end
	end

	assign q_push = rx_fire && open_q && is_term && count_q != '0;
	assign q_data = ent;

	// line bookkeeping, led and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tlen_q  <= '0;
			zero_q  <= 1'b0;
			red_q   <= 1'b0;
			green_q <= 1'b0;
			blue_q  <= 1'b0;
			open_q  <= 1'b1;
		end else if (rx_fire && open_q) begin
			if (is_term) begin
				if (count_q != '0) begin
					count_q <= '0;
					tlen_q  <= '0;
					zero_q  <= 1'b0;
					red_q   <= ent.red;
					green_q <= ent.green;
					blue_q  <= ent.blue;
					open_q  <= ent.open;
				end
			end else if (count_q < CNT_W'(LINE_MAX)) begin
				count_q <= count_q + CNT_W'(1);
				if (!zero_q) begin
					if (rx_byte == CH_NUL) begin
						zero_q <= 1'b1;
					end else begin
						tlen_q <= tlen_q + CNT_W'(1);
					end
				end
			end
		end
	end

	// character store, only the leading characters are kept
	always_ff @(posedge clk) begin
		if (rx_fire && open_q && !is_term && count_q < CNT_W'(LINE_MAX) && !zero_q &&
			rx_byte != CH_NUL && tlen_q < CNT_W'(TXT_KEEP)) begin
			text_q[tlen_q[TXT_IW-1:0]] <= rx_byte;
		end
	end

endmodule

// ----- design/sli_fifo.sv -----
// short queue of classified lines between front and back
// depends on sli_pkg for the entry type and depth
module sli_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sli_pkg::entry_t wdata,
	input  logic            pop,
	output sli_pkg::entry_t rdata,
	output logic            full,
	output logic            empty
);
	import sli_pkg::*;

	entry_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wptr_q, rptr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 do_push, do_pop;

	assign full    = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + FIFO_PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + FIFO_PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ----- design/sli_back.sv -----
// back end: takes one classified line at a time and streams its reply bytes
// depends on sli_pkg; holds the clock register and the decimal converter
module sli_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [sli_pkg::CLK_W-1:0] cfg_wdata,
	input  logic                     q_empty,
	input  sli_pkg::entry_t          q_data,
	output logic                     q_pop,
	output logic                     tx_valid,
	input  logic                     tx_stall,
	output logic [7:0]               tx_byte,
	output logic                     last_of_reply,
	output logic                     led_red,
	output logic                     led_green,
	output logic                     led_blue,
	output logic                     link_open
);
	import sli_pkg::*;

	bstate_t             state_q, state_d;
	logic [CLK_W-1:0]    clock_hz_q;
	entry_t              ent_q;
	logic [IDX_W-1:0]    idx_q, len_q;
	logic [CLK_W-1:0]    bin_q;
	logic [BCD_W-1:0]    bcd_q, bcd_adj;
	logic [CONV_CW-1:0]  cnt_q;
	logic [3:0]          ndig_q;
	logic                ov_q;

	logic                adv, load;
	logic [7:0]          cur_byte;
	logic                cur_last, in_digits;
	logic [IDX_W-1:0]    dig_end;

	// clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLK_RESET;
		end else if (cfg_we) begin
			clock_hz_q <= cfg_wdata;
		end
	end

	// add-3 correction of every bcd digit before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
	end

	// current reply byte
	assign dig_end   = LEN_UPHEAD + IDX_W'(ndig_q);
	assign in_digits = idx_q >= LEN_UPHEAD && idx_q < dig_end;
	always_comb begin
		if (ent_q.cmd == CMD_UPTIME) begin
			if (idx_q < LEN_UPHEAD) begin
				cur_byte = txt_at(TXT_UPHEAD, LEN_UPHEAD, idx_q);
			end else if (in_digits) begin
				cur_byte = CH_ZERO | {4'd0, bcd_q[BCD_W-1 -: 4]};
			end else if (idx_q == dig_end) begin
				cur_byte = CH_CR;
			end else begin
				cur_byte = CH_LF;
			end
		end else if (ent_q.cmd == CMD_STATE && idx_q == POS_RED) begin
			cur_byte = ent_q.red ? CH_ONE : CH_ZERO;
		end else if (ent_q.cmd == CMD_STATE && idx_q == POS_GREEN) begin
			cur_byte = ent_q.green ? CH_ONE : CH_ZERO;
		end else if (ent_q.cmd == CMD_STATE && idx_q == POS_BLUE) begin
			cur_byte = ent_q.blue ? CH_ONE : CH_ZERO;
		end else begin
			cur_byte = msg_byte(ent_q.cmd, idx_q);
		end
	end
	assign cur_last = idx_q == len_q - IDX_W'(1);

	assign adv  = !ov_q || !tx_stall;
	assign load = state_q == B_SEND && adv;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_data.cmd == CMD_UPTIME) ? B_CONV : B_SEND;
				end
			end
			B_CONV: begin
				if (cnt_q == CONV_CW'(CLK_W - 1)) begin
					state_d = B_TRIM;
				end
			end
			B_TRIM: begin
				if (bcd_q[BCD_W-1 -: 4] != 4'd0 || ndig_q == 4'd1) begin
					state_d = B_SEND;
				end
			end
			B_SEND: begin
				if (load && cur_last) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (!tx_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// reply work registers: entry, byte index, binary to decimal conversion
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				ent_q  <= q_data;
				idx_q  <= '0;
				len_q  <= msg_len(q_data.cmd);
				bin_q  <= clock_hz_q;
				bcd_q  <= '0;
				cnt_q  <= '0;
				ndig_q <= 4'(DIGITS);
			end
			B_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[CLK_W-1]};
				bin_q <= {bin_q[CLK_W-2:0], 1'b0};
				cnt_q <= cnt_q + CONV_CW'(1);
			end
			B_TRIM: begin
				if (bcd_q[BCD_W-1 -: 4] != 4'd0 || ndig_q == 4'd1) begin
					len_q <= LEN_UPHEAD + IDX_W'(ndig_q) + LEN_UPTAIL;
				end else begin
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					ndig_q <= ndig_q - 4'd1;
				end
			end
			B_SEND: begin
				if (load) begin
					idx_q <= idx_q + IDX_W'(1);
					if (ent_q.cmd == CMD_UPTIME && in_digits) begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte       <= cur_byte;
			last_of_reply <= cur_last;
			led_red       <= ent_q.red;
			led_green     <= ent_q.green;
			led_blue      <= ent_q.blue;
			link_open     <= ent_q.open;
		end
	end

	assign tx_valid = ov_q;

endmodule

// ----- design/serial_led_command_interpreter_top.sv -----
// Serial LED command interpreter: bytes in, reply text bytes out.
// Throughput: one received byte per cycle while the two-entry line queue has room; reply
// bytes leave at one per cycle while tx_stall is low, with an idle state between replies.
// Uptime replies first run 27 bit-serial conversion steps, then trim up to 8 leading zeros.
// Reset (arst_n low, asynchronous) clears the line, led state off, session open, clock
// 16000000; the led and link_open output registers have no reset.
module serial_led_command_interpreter_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sli_pkg::CLK_W-1:0] cfg_wdata,
	input  logic                      rx_valid,
	output logic                      rx_stall,
	input  logic [7:0]                rx_byte,
	output logic                      tx_valid,
	input  logic                      tx_stall,
	output logic [7:0]                tx_byte,
	output logic                      last_of_reply,
	output logic                      led_red,
	output logic                      led_green,
	output logic                      led_blue,
	output logic                      link_open
);
	import sli_pkg::*;

	entry_t push_data, pop_data;
	logic   push, pop, full, empty;

	// line gathering and classification
	sli_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// queue of classified lines
	sli_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (pop_data),
		.full   (full),
		.empty  (empty)
	);

	// reply generation
	sli_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_empty       (empty),
		.q_data        (pop_data),
		.q_pop         (pop),
		.tx_valid      (tx_valid),
		.tx_stall      (tx_stall),
		.tx_byte       (tx_byte),
		.last_of_reply (last_of_reply),
		.led_red       (led_red),
		.led_green     (led_green),
		.led_blue      (led_blue),
		.link_open     (link_open)
	);

endmodule
